// File: hw/rtl/rtc_bcd_register_codec_macros.svh
// Assertion macros for the RTC BCD register codec.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef RTC_BCD_REGISTER_CODEC_MACROS_SVH
`define RTC_BCD_REGISTER_CODEC_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define RBC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbc assertion failed");

// Next-cycle implication, disabled in reset.
`define RBC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbc assertion failed");

`else

`define RBC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RBC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/rbc_pkg.sv
// Package for the RTC BCD register codec: codes, constants, result type
// and the BCD helper functions. No dependencies.
`default_nettype none

package rbc_pkg;

    typedef enum logic {
        ACTION_DECODE = 1'b0,
        ACTION_ENCODE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BIT_ERR   = 2'd1,
        STATUS_RANGE_ERR = 2'd2
    } status_t;

    localparam logic [7:0]  CTRL_MASK   = 8'h6C;
    localparam logic [7:0]  HALT_CLEAR  = 8'h7F;
    localparam logic [11:0] YEAR_BASE   = 12'd2000;
    localparam logic [7:0]  YEAR_MAX    = 8'd99;
    localparam logic [6:0]  MINUTE_MAX  = 7'd59;
    localparam logic [6:0]  HOUR_MAX    = 7'd23;
    localparam logic [2:0]  WEEKDAY_MAX = 3'd6;
    localparam logic [5:0]  DAY_MAX     = 6'd31;
    localparam logic [4:0]  MONTH_MAX   = 5'd12;

    typedef struct packed {
        status_t     status;
        logic [6:0]  minute;
        logic [6:0]  hour;
        logic [2:0]  weekday;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [11:0] year;
        logic [55:0] image;
    } result_t;

    // Binary to packed BCD for values below 100; tens by reciprocal multiply.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

    // Remainder by 100 of a 14-bit value via reciprocal multiply.
    function automatic logic [6:0] mod_100(input logic [13:0] v);
        logic [26:0] prod;
        logic [7:0]  quot;
        logic [13:0] rem;
        prod = 27'(v) * 27'd5243;
        quot = prod[26:19];
        rem  = v - 14'(quot) * 14'd100;
        return rem[6:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtc_bcd_register_codec.sv
// RTC BCD register codec
//
// Converts between an RTC chip's eight-byte BCD register image and binary
// date and time. action = decode: checks reserved bits and field ranges
// of reg_image and returns status plus the binary fields (year + 2000);
// fields are zero unless status is ok, and image_out is zero.
// action = encode: packs the binary inputs into seven BCD bytes on
// image_out, keeping byte 0 of reg_image with its halt bit cleared and
// reducing the year modulo 100; status and binary outputs are zero.
// Input and output channels are valid/ready. An accepted item is held in
// an input register, converted, and placed in the result register, from
// which it is offered on out_valid. One item is accepted per cycle while
// the receiver takes results; the valid/ready pipeline between the two
// registers sets that rate.
// When the receiver stalls, the result register holds and the input
// register can still take one more item; after that in_ready drops.
// Reset empties both registers; no result is pending after reset.
//
// Depends on rbc_pkg and rtc_bcd_register_codec_macros.svh.
`default_nettype none
`include "rtc_bcd_register_codec_macros.svh"

module rtc_bcd_register_codec
    import rbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [63:0] reg_image,
    input  wire logic [5:0]  minute_in,
    input  wire logic [4:0]  hour_in,
    input  wire logic [2:0]  weekday_in,
    input  wire logic [4:0]  day_in,
    input  wire logic [3:0]  month_in,
    input  wire logic [13:0] year_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [6:0]       minute_out,
    output logic [6:0]       hour_out,
    output logic [2:0]       weekday_out,
    output logic [5:0]       day_out,
    output logic [4:0]       month_out,
    output logic [11:0]      year_out,
    output logic [55:0]      image_out
);

    logic        s1_valid_reg, s1_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        action_reg;
    logic [63:0] image_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  hour_reg;
    logic [2:0]  weekday_reg;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [13:0] year_reg;
    result_t     result_reg, result_next;
    logic        advance;

    logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
    logic [6:0]  dec_minute, dec_hour;
    logic [5:0]  dec_day;
    logic [4:0]  dec_month;
    logic [7:0]  dec_year;
    logic        bit_err, range_err;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg  <= action;
            image_reg   <= reg_image;
            minute_reg  <= minute_in;
            hour_reg    <= hour_in;
            weekday_reg <= weekday_in;
            day_reg     <= day_in;
            month_reg   <= month_in;
            year_reg    <= year_in;
        end
        if (advance && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign b0 = image_reg[7:0];
    assign b1 = image_reg[15:8];
    assign b2 = image_reg[23:16];
    assign b3 = image_reg[31:24];
    assign b4 = image_reg[39:32];
    assign b5 = image_reg[47:40];
    assign b6 = image_reg[55:48];
    assign b7 = image_reg[63:56];

    // Unpack BCD; digits above 9 keep their raw weight.
    assign dec_minute = 7'(b1[6:4]) * 7'd10 + 7'(b1[3:0]);
    assign dec_hour   = 7'(b2[6:4]) * 7'd10 + 7'(b2[3:0]);
    assign dec_day    = 6'(b4[5:4]) * 6'd10 + 6'(b4[3:0]);
    assign dec_month  = 5'(b5[4]) * 5'd10 + 5'(b5[3:0]);
    assign dec_year   = 8'(b6[7:4]) * 8'd10 + 8'(b6[3:0]);

    assign bit_err = b0[7] || b1[7] || b2[7] || (b3[7:3] != 5'd0)
                  || (b4[7:6] != 2'd0) || (b5[7:5] != 3'd0)
                  || ((b7 & CTRL_MASK) != 8'd0);

    assign range_err = (dec_minute > MINUTE_MAX) || (dec_hour > HOUR_MAX)
                    || (b3[2:0] > WEEKDAY_MAX) || (dec_month > MONTH_MAX)
                    || (dec_day > DAY_MAX) || (dec_day == 6'd0)
                    || (dec_month == 5'd0) || (dec_year > YEAR_MAX);

    always_comb
    begin
        result_next = '0;
        result_next.status = STATUS_OK;
        if (action_reg == ACTION_ENCODE)
        begin
            result_next.image = {to_bcd(mod_100(year_reg)),
                                 to_bcd(7'(month_reg)),
                                 to_bcd(7'(day_reg)),
                                 5'd0, weekday_reg,
                                 to_bcd(7'(hour_reg)),
                                 to_bcd(7'(minute_reg)),
                                 b0 & HALT_CLEAR};
        end
        else
        begin
            priority if (bit_err)
            begin
                result_next.status = STATUS_BIT_ERR;
            end
            else if (range_err)
            begin
                result_next.status = STATUS_RANGE_ERR;
            end
            else
            begin
                result_next.minute  = dec_minute;
                result_next.hour    = dec_hour;
                result_next.weekday = b3[2:0];
                result_next.day     = dec_day;
                result_next.month   = dec_month;
                result_next.year    = 12'(dec_year) + YEAR_BASE;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign minute_out  = result_reg.minute;
    assign hour_out    = result_reg.hour;
    assign weekday_out = result_reg.weekday;
    assign day_out     = result_reg.day;
    assign month_out   = result_reg.month;
    assign year_out    = result_reg.year;
    assign image_out   = result_reg.image;

    `RBC_ASSERT_IMP(a_fail_zero, clk, rst_n,
        out_valid_reg && result_reg.status != STATUS_OK,
        result_reg.minute == 7'd0 && result_reg.year == 12'd0 && result_reg.image == 56'd0)

    `RBC_ASSERT_IMP(a_encode_clean, clk, rst_n,
        out_valid_reg && result_reg.image != 56'd0,
        result_reg.status == STATUS_OK && result_reg.year == 12'd0 && result_reg.day == 6'd0)

    `RBC_ASSERT_IMP(a_decode_year, clk, rst_n,
        out_valid_reg && result_reg.year != 12'd0,
        result_reg.year >= YEAR_BASE && result_reg.year <= YEAR_BASE + 12'(YEAR_MAX)
        && result_reg.image == 56'd0)

    `RBC_ASSERT_NXT(a_advance, clk, rst_n,
        s1_valid_reg && !out_valid_reg,
        out_valid_reg)

endmodule

`default_nettype wire

// File: bench/tb_rtc_bcd_register_codec.sv
// Testbench for rtc_bcd_register_codec: queued stimulus, clocked driver and monitor,
// and a built-in predictor of the BCD decode and encode conversions.
// Depends on rbc_pkg and the codec RTL.
`default_nettype none

module tb_rtc_bcd_register_codec
    import rbc_pkg::*;
;

    localparam int RANDOM_ITEMS   = 1530;
    localparam int MAX_PAUSE      = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SHOW_LIMIT     = 10;

    typedef struct {
        action_t     action;
        logic [63:0] image;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        int          gap;
    } conv_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [63:0] reg_image = '0;
    logic [5:0]  minute_in = '0;
    logic [4:0]  hour_in = '0;
    logic [2:0]  weekday_in = '0;
    logic [4:0]  day_in = '0;
    logic [3:0]  month_in = '0;
    logic [13:0] year_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [6:0]  minute_out;
    logic [6:0]  hour_out;
    logic [2:0]  weekday_out;
    logic [5:0]  day_out;
    logic [4:0]  month_out;
    logic [11:0] year_out;
    logic [55:0] image_out;

    conv_req_t req_queue[$];
    result_t   result_queue[$];
    conv_req_t cur_req;
    result_t   got;
    result_t   want;
    int        hold_cnt = 0;
    int        rx_wait = 0;
    int        rx_limit = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;
    int        rx_count = 0;
    int        fault_count = 0;
    int        idle_cycles = 0;

    rtc_bcd_register_codec DUT (
        .clk, .rst_n,
        .in_valid, .in_ready,
        .action, .reg_image, .minute_in, .hour_in, .weekday_in, .day_in, .month_in, .year_in,
        .out_valid, .out_ready,
        .status, .minute_out, .hour_out, .weekday_out, .day_out, .month_out, .year_out,
        .image_out
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] bcd_byte(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic result_t convert_req(input conv_req_t it);
        result_t    r;
        logic [7:0] b [8];
        logic [6:0] mi;
        logic [6:0] hr;
        logic [2:0] wd;
        logic [5:0] dy;
        logic [4:0] mo;
        logic [7:0] yr;
        logic [6:0] yr_mod;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            b[k] = it.image[8*k +: 8];
        end
        if (it.action == ACTION_DECODE)
        begin
            if (b[0][7] || b[1][7] || b[2][7] || b[3][7:3] != 5'd0 || b[4][7:6] != 2'd0 ||
                b[5][7:5] != 3'd0 || (b[7] & CTRL_MASK) != 8'd0)
            begin
                r.status = STATUS_BIT_ERR;
            end
            else
            begin
                mi = 7'd10 * 7'(b[1][6:4]) + 7'(b[1][3:0]);
                hr = 7'd10 * 7'(b[2][6:4]) + 7'(b[2][3:0]);
                wd = b[3][2:0];
                dy = 6'd10 * 6'(b[4][5:4]) + 6'(b[4][3:0]);
                mo = 5'd10 * 5'(b[5][4]) + 5'(b[5][3:0]);
                yr = 8'd10 * 8'(b[6][7:4]) + 8'(b[6][3:0]);
                if (mi > MINUTE_MAX || hr > HOUR_MAX || wd > WEEKDAY_MAX || dy > DAY_MAX ||
                    dy == 6'd0 || mo > MONTH_MAX || mo == 5'd0 || yr > YEAR_MAX)
                begin
                    r.status = STATUS_RANGE_ERR;
                end
                else
                begin
                    r.status  = STATUS_OK;
                    r.minute  = mi;
                    r.hour    = hr;
                    r.weekday = wd;
                    r.day     = dy;
                    r.month   = mo;
                    r.year    = YEAR_BASE + 12'(yr);
                end
            end
        end
        else
        begin
            yr_mod  = 7'(it.year % 14'd100);
            r.image = {bcd_byte(yr_mod), bcd_byte(it.month), bcd_byte(it.day),
                       5'd0, it.weekday, bcd_byte(it.hour), bcd_byte(it.minute),
                       b[0] & HALT_CLEAR};
        end
        return r;
    endfunction

    function automatic logic [63:0] clock_image(input logic [7:0] sec, input int mi,
                                                input int hr, input int wd, input int dy,
                                                input int mo, input int yr,
                                                input logic [7:0] ctrl);
        return {ctrl, bcd_byte(yr), bcd_byte(mo), bcd_byte(dy), 8'(wd),
                bcd_byte(hr), bcd_byte(mi), sec};
    endfunction

    function automatic logic [63:0] random_clock_image();
        return clock_image(8'($urandom_range(0, 127)), $urandom_range(0, 59),
                           $urandom_range(0, 23), $urandom_range(0, 6),
                           $urandom_range(1, 31), $urandom_range(1, 12),
                           $urandom_range(0, 99), 8'($urandom()) & ~CTRL_MASK);
    endfunction

    function automatic conv_req_t decode_req(input logic [63:0] img);
        conv_req_t r;
        r.action  = ACTION_DECODE;
        r.image   = img;
        r.minute  = 6'($urandom());
        r.hour    = 5'($urandom());
        r.weekday = 3'($urandom());
        r.day     = 5'($urandom());
        r.month   = 4'($urandom());
        r.year    = 14'($urandom());
        r.gap     = 0;
        return r;
    endfunction

    function automatic conv_req_t encode_req(input logic [63:0] img, input int mi, input int hr,
                                             input int wd, input int dy, input int mo,
                                             input int yr);
        conv_req_t r;
        r.action  = ACTION_ENCODE;
        r.image   = img;
        r.minute  = 6'(mi);
        r.hour    = 5'(hr);
        r.weekday = 3'(wd);
        r.day     = 5'(dy);
        r.month   = 4'(mo);
        r.year    = 14'(yr);
        r.gap     = 0;
        return r;
    endfunction

    task automatic push_req(input conv_req_t r);
        r.gap = tx_calm ? 0 : $urandom_range(0, MAX_PAUSE);
        req_queue.push_back(r);
    endtask

    // driver: hold the item until accepted, then wait the next item's gap before presenting it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                result_queue.push_back(convert_req(cur_req));
            end
            if (!in_valid || in_ready)
            begin
                if (req_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (hold_cnt < req_queue[0].gap)
                begin
                    in_valid <= 1'b0;
                    hold_cnt <= hold_cnt + 1;
                end
                else
                begin
                    cur_req    = req_queue.pop_front();
                    in_valid   <= 1'b1;
                    action     <= cur_req.action;
                    reg_image  <= cur_req.image;
                    minute_in  <= cur_req.minute;
                    hour_in    <= cur_req.hour;
                    weekday_in <= cur_req.weekday;
                    day_in     <= cur_req.day;
                    month_in   <= cur_req.month;
                    year_in    <= cur_req.year;
                    hold_cnt   <= 0;
                end
            end
        end
    end

    // monitor: check each result, then stall a drawn number of cycles before the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {status, minute_out, hour_out, weekday_out, day_out, month_out,
                       year_out, image_out};
                if (result_queue.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("unexpected result: status=%0d image=%h", status, image_out);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (got !== want)
                    begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT)
                        begin
                            $display("mismatch exp: st=%0d mi=%0d hr=%0d wd=%0d dy=%0d mo=%0d yr=%0d img=%h",
                                     want.status, want.minute, want.hour, want.weekday,
                                     want.day, want.month, want.year, want.image);
                            $display("         got: st=%0d mi=%0d hr=%0d wd=%0d dy=%0d mo=%0d yr=%0d img=%h",
                                     got.status, got.minute, got.hour, got.weekday,
                                     got.day, got.month, got.year, got.image);
                        end
                    end
                end
                rx_count++;
                if (rx_count % 80 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                rx_wait  = 0;
                rx_limit = rx_calm ? 0 : $urandom_range(0, MAX_PAUSE);
            end
            else if (out_valid && !out_ready)
            begin
                rx_wait++;
            end
            out_ready <= (rx_wait >= rx_limit);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] base;
        logic [63:0] img;
        int          pick;

        // directed: field extremes, each reserved field, each range check, encode extremes
        base = clock_image(8'h00, 0, 0, 0, 1, 1, 0, 8'h00);
        push_req(decode_req(clock_image(8'h59, 59, 23, 6, 31, 12, 99, 8'h93)));
        push_req(decode_req(base));
        push_req(decode_req(64'd0));
        push_req(decode_req('1));
        push_req(decode_req(base | (64'd1 << 7)));
        push_req(decode_req(base | (64'd1 << 15)));
        push_req(decode_req(base | (64'd1 << 23)));
        push_req(decode_req(base | (64'd1 << 27)));
        push_req(decode_req(base | (64'd1 << 38)));
        push_req(decode_req(base | (64'd1 << 45)));
        push_req(decode_req(base | {CTRL_MASK, 56'd0}));
        push_req(decode_req(base | (64'd1 << 22)));
        push_req(decode_req(clock_image(8'h00, 60, 0, 0, 1, 1, 0, 8'h00)));
        push_req(decode_req(clock_image(8'h00, 0, 24, 0, 1, 1, 0, 8'h00)));
        push_req(decode_req(clock_image(8'h00, 0, 0, 7, 1, 1, 0, 8'h00)));
        push_req(decode_req(clock_image(8'h00, 0, 0, 0, 32, 1, 0, 8'h00)));
        push_req(decode_req(clock_image(8'h00, 0, 0, 0, 1, 13, 0, 8'h00)));
        push_req(decode_req(clock_image(8'h00, 0, 0, 0, 1, 0, 0, 8'h00)));
        img = base;
        img[55:48] = 8'hA5;
        push_req(decode_req(img));
        img = base;
        img[15:8] = 8'h4F;
        push_req(decode_req(img));
        push_req(encode_req('1, 59, 23, 6, 31, 12, 9999));
        push_req(encode_req(64'd0, 0, 0, 0, 0, 0, 0));
        push_req(encode_req({$urandom(), $urandom()}, 63, 31, 7, 31, 15, 16383));
        push_req(encode_req(64'h7F, 0, 0, 0, 1, 1, 2099));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 80 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                push_req(decode_req(random_clock_image()));
            end
            else if (pick < 50)
            begin
                push_req(decode_req(random_clock_image() ^ (64'd1 << $urandom_range(0, 63))));
            end
            else if (pick < 60)
            begin
                img = {8'($urandom()) & ~CTRL_MASK, 8'($urandom()),
                       3'd0, 5'($urandom()), 2'd0, 6'($urandom()), 5'd0, 3'($urandom()),
                       1'b0, 7'($urandom()), 1'b0, 7'($urandom()), 1'b0, 7'($urandom())};
                push_req(decode_req(img));
            end
            else if (pick < 70)
            begin
                push_req(decode_req({$urandom(), $urandom()}));
            end
            else if (pick < 90)
            begin
                push_req(encode_req({$urandom(), $urandom()}, $urandom_range(0, 59),
                                    $urandom_range(0, 23), $urandom_range(0, 6),
                                    $urandom_range(1, 31), $urandom_range(1, 12),
                                    $urandom_range(0, 9999)));
            end
            else
            begin
                push_req(encode_req({$urandom(), $urandom()}, $urandom_range(0, 63),
                                    $urandom_range(0, 31), $urandom_range(0, 7),
                                    $urandom_range(0, 31), $urandom_range(0, 15),
                                    $urandom_range(0, 16383)));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (req_queue.size() != 0 || in_valid || result_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/rbc_pkg.sv
hw/rtl/rtc_bcd_register_codec.sv
bench/tb_rtc_bcd_register_codec.sv
